// ===== hdl/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg
// shared types, codes and constants of the animation frame sequencer
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned ELAPSED_W  = 20;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned SEED_W     = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd33333;
  localparam logic [SEED_W-1:0]   SEED_RESET   = 16'd44257;
  localparam logic [SEED_W-1:0]   LFSR_TAPS    = 16'hB400;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_START  = 2'd3
  } afs_op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_ONCE       = 3'd0,
    MODE_REVERSE    = 3'd1,
    MODE_REPEAT     = 3'd2,
    MODE_REV_REPEAT = 3'd3,
    MODE_PINGPONG   = 3'd4,
    MODE_RANDOM     = 3'd5
  } afs_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAY_MODE    = 2'd0,
    CFG_FRAME_PERIOD = 2'd1,
    CFG_END_NOTIFY   = 2'd2,
    CFG_RANDOM_SEED  = 2'd3
  } afs_cfg_e;

  typedef struct packed {
    afs_op_e                operation;
    logic [ELAPSED_W-1:0]   elapsed;
    logic [KEY_W-1:0]       key_frame_value;
  } afs_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_frame;
    logic [POS_W-1:0] frame_position;
    logic             frame_changed;
    logic             animation_end;
  } afs_out_t;

  // galois step, shift right, taps applied when the dropped bit is set
  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

// ===== hdl/afs_ram.sv =====
// ----------------------------------------------------------------------------
// afs_ram
// generic one write, one read ram with registered read data
// ----------------------------------------------------------------------------
module afs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/afs_div.sv =====
// ----------------------------------------------------------------------------
// afs_div
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module afs_div #(
  parameter int unsigned DIVIDEND_W = 32,
  parameter int unsigned DIVISOR_W  = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [DIVISOR_W-1:0]  remainder_o
);

  localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  done_q, done_d;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};

    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CW'(DIVIDEND_W);
    end else if (cnt_q != '0) begin
      quo_d  = {quo_q[DIVIDEND_W-2:0], ge};
      rem_d  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== hdl/animation_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// animation_frame_sequencer
// key-frame table with time accumulator; each tick maps elapsed time (an lfsr
// value in random mode) to a table entry by play mode using one shared serial divider
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 word
// in        input      in_valid_i / in_stall_o   afs_in_t: operation, elapsed, key value
// out       output     out_valid_o / out_stall_i afs_out_t: key, position, changed, end
// cfg       input      cfg_valid_i / cfg_ready_o register index and write data
//
// append, clear, start and a single-frame tick are handled in the idle state
// a tick in once or reverse mode takes one divider pass
// random takes one modulo pass on the lfsr
// repeat, reverse repeat and ping-pong run the shared divider on time/period and
// then on frame mod count (mod 2*count-2 for ping-pong), one bit a cycle
// reset is asynchronous; the table needs no clearing, only entries below the
// count are read
// a result waits in the output register under stall while the block takes the
// next word; a finished tick holds until that register is free
// ----------------------------------------------------------------------------
module animation_frame_sequencer #(
  parameter int unsigned MAX_FRAMES = 128,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  afs_pkg::afs_in_t                      in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output afs_pkg::afs_out_t                     out_word_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [afs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [afs_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  import afs_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_FRAMES);
  // divisor holds the period or up to 2*count-2
  localparam int unsigned DIV_W  = (PERIOD_W > CNT_W + 1) ? PERIOD_W : CNT_W + 1;
  localparam int unsigned SUM_W  = ((TIME_WIDTH > ELAPSED_W) ? TIME_WIDTH : ELAPSED_W) + 1;
  localparam int unsigned POSX_W = (IDX_W > POS_W) ? IDX_W : POS_W;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MOD  = 5'b00100,
    ST_READ = 5'b01000,
    ST_FIN  = 5'b10000
  } afs_state_e;

  afs_state_e st_q, st_d;

  // configuration
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                notify_q, notify_d;

  // sequencer state
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] acc_q, acc_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [KEY_W-1:0]      cur_key_q, cur_key_d;
  logic [SEED_W-1:0]     lfsr_q, lfsr_d;
  logic                  ended_q, ended_d;
  logic                  empty_q, empty_d;
  logic [IDX_W-1:0]      idx_q, idx_d;

  // output register
  afs_out_t out_q, out_d;
  logic     out_valid_q, out_valid_d;

  // shared divider
  logic                  div_start;
  logic [TIME_WIDTH-1:0] div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic                  div_done;
  logic [TIME_WIDTH-1:0] quo;
  logic [DIV_W-1:0]      rem;

  // table
  logic             ram_we;
  logic [KEY_W-1:0] ram_rdata;

  // helpers
  logic [SUM_W-1:0]      sum;
  logic [TIME_WIDTH-1:0] acc_sat;
  logic [TIME_WIDTH-1:0] nm1_t;
  logic [DIV_W-1:0]      nd;
  logic [DIV_W-1:0]      pp;
  logic [DIV_W-1:0]      period_ext;
  logic [SEED_W-1:0]     lfsr_nx;
  logic                  end_hit;
  logic                  full;
  logic [KEY_W-1:0]      key_sel;
  logic [POSX_W-1:0]     pos_ext;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    sum        = SUM_W'(acc_q) + SUM_W'(in_word_i.elapsed);
    // accumulator saturates at all ones
    acc_sat    = (sum > SUM_W'({TIME_WIDTH{1'b1}})) ? {TIME_WIDTH{1'b1}}
                                                      : sum[TIME_WIDTH-1:0];
    nm1_t      = TIME_WIDTH'(cnt_q) - TIME_WIDTH'(1);
    nd         = DIV_W'(cnt_q);
    pp         = (nd << 1) - DIV_W'(2);
    // zero period acts as one
    period_ext = (period_q == '0) ? DIV_W'(1) : DIV_W'(period_q);
    lfsr_nx    = lfsr_step(lfsr_q);
    full       = (cnt_q == CNT_W'(MAX_FRAMES));
    key_sel    = empty_q ? KEY_W'(1) : ram_rdata;
    pos_ext    = POSX_W'(idx_q);
  end

  // end of animation, judged on the position from before the tick
  always_comb begin
    case (mode_q)
      MODE_REVERSE, MODE_REV_REPEAT: end_hit = (pos_q == '0);
      MODE_PINGPONG:                 end_hit = (pos_q == IDX_W'(1));
      MODE_RANDOM:                   end_hit = 1'b0;
      default:                       end_hit = ((CNT_W'(pos_q) + CNT_W'(1)) == cnt_q);
    endcase
  end

  always_comb begin
    st_d        = st_q;
    mode_d      = mode_q;
    period_d    = period_q;
    notify_d    = notify_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    cur_key_d   = cur_key_q;
    lfsr_d      = lfsr_q;
    ended_d     = ended_q;
    empty_d     = empty_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start    = 1'b0;
    div_dividend = acc_q;
    div_divisor  = period_ext;
    ram_we       = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_word_i.operation)
            OP_APPEND: begin
              // appends to a full table are dropped
              if (!full) begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            OP_START: begin
              acc_d = '0;
              if ((mode_q == MODE_REVERSE || mode_q == MODE_REV_REPEAT) && cnt_q != '0) begin
                pos_d     = IDX_W'(cnt_q - CNT_W'(1));
                cur_key_d = KEY_W'(cnt_q - CNT_W'(1));
              end else begin
                pos_d     = '0;
                cur_key_d = '0;
              end
            end
            OP_TICK: begin
              // single frame: tick is a no-op
              if (cnt_q != CNT_W'(1)) begin
                ended_d = notify_q && end_hit;
                acc_d   = acc_sat;
                if (cnt_q == '0) begin
                  empty_d = 1'b1;
                  idx_d   = '0;
                  st_d    = ST_FIN;
                end else begin
                  empty_d = 1'b0;
                  div_start = 1'b1;
                  if (mode_q == MODE_RANDOM) begin
                    lfsr_d       = lfsr_nx;
                    div_dividend = TIME_WIDTH'(lfsr_nx);
                    div_divisor  = nd - DIV_W'(1);
                    st_d         = ST_MOD;
                  end else begin
                    st_d = ST_DIV;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        // quo is the frame index before the tick
        if (div_done) begin
          case (mode_q)
            MODE_REPEAT, MODE_REV_REPEAT: begin
              div_start    = 1'b1;
              div_dividend = quo;
              div_divisor  = nd;
              st_d         = ST_MOD;
            end
            MODE_PINGPONG: begin
              div_start    = 1'b1;
              div_dividend = quo;
              div_divisor  = pp;
              st_d         = ST_MOD;
            end
            MODE_REVERSE: begin
              idx_d = (quo >= nm1_t) ? '0 : IDX_W'(nm1_t - quo);
              st_d  = ST_READ;
            end
            default: begin
              idx_d = (quo < nm1_t) ? IDX_W'(quo) : IDX_W'(nm1_t);
              st_d  = ST_READ;
            end
          endcase
        end
      end
      ST_MOD: begin
        if (div_done) begin
          case (mode_q)
            MODE_REV_REPEAT: idx_d = IDX_W'(nd - DIV_W'(1) - rem);
            // reflect the upper half of the ping-pong period
            MODE_PINGPONG:   idx_d = (rem >= nd) ? IDX_W'(pp - rem) : IDX_W'(rem);
            default:         idx_d = IDX_W'(rem);
          endcase
          st_d = ST_READ;
        end
      end
      ST_READ: begin
        // table read at idx_q lands in the ram output register
        st_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.key_frame      = key_sel;
          out_d.frame_position = pos_ext[POS_W-1:0];
          out_d.frame_changed  = (key_sel != cur_key_q);
          out_d.animation_end  = ended_q;
          out_valid_d          = 1'b1;
          cur_key_d            = key_sel;
          pos_d                = idx_q;
          st_d                 = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // configuration writes must arrive only while idle; the block does not enforce this
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PLAY_MODE:    mode_d   = cfg_data_i[MODE_W-1:0];
        CFG_FRAME_PERIOD: period_d = cfg_data_i[PERIOD_W-1:0];
        CFG_END_NOTIFY:   notify_d = cfg_data_i[0];
        CFG_RANDOM_SEED:  lfsr_d   = cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mode_q      <= MODE_ONCE;
      period_q    <= PERIOD_RESET;
      notify_q    <= 1'b0;
      cnt_q       <= '0;
      acc_q       <= '0;
      pos_q       <= '0;
      cur_key_q   <= '0;
      lfsr_q      <= SEED_RESET;
      ended_q     <= 1'b0;
      empty_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      mode_q      <= mode_d;
      period_q    <= period_d;
      notify_q    <= notify_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      cur_key_q   <= cur_key_d;
      lfsr_q      <= lfsr_d;
      ended_q     <= ended_d;
      empty_q     <= empty_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  afs_div #(
    .DIVIDEND_W (TIME_WIDTH),
    .DIVISOR_W  (DIV_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  afs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (in_word_i.key_frame_value),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_FRAMES))
    else $error("frame count above table depth");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == ST_DIV || st_q == ST_MOD))
    else $error("divider finished outside a divide state");

  a_full_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.operation == OP_APPEND && full)
      |=> $stable(cnt_q))
    else $error("append to full table changed the count");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> (cnt_q != CNT_W'(1)))
    else $error("tick started with a single frame");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_READ) |-> (CNT_W'(idx_q) < cnt_q))
    else $error("mapped index beyond loaded frames");
`endif

endmodule
